// ===== hdl/acq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alert confirmation qualifier package
// Shared types and constants for the alert confirmation qualifier.
// ----------------------------------------------------------------------------
package acq_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int CLASS_W     = 2;
   localparam int OPCODE_W    = 2;
   localparam int CONF_W      = 16;
   localparam int SRC_W       = 8;
   localparam int TIME_IN_W   = 32;
   localparam int TOTAL_W     = 24;
   localparam int COUNT_W     = 16;
   localparam int FRAMES_W    = 8;
   localparam int CONFIRM_W   = 8;
   localparam int HOLDOFF_W   = 32;
   localparam int NEG_W       = 2;
   localparam int NUM_CONFIRM = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [NEG_W-1:0]     NEG_CLEAR     = 2'd3;
   localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 8'd3;
   localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 32'd30000;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_FRAME = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   // Alert classes.
   localparam logic [CLASS_W-1:0] CLASS_FALL    = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_FIRE    = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_SMOKE   = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_ANOMALY = 2'd3;

   // Slots of the confirm register array.
   localparam int CONFIRM_FALL       = 0;
   localparam int CONFIRM_FIRE_SMOKE = 1;
   localparam int CONFIRM_ANOMALY    = 2;

   // Register indexes of the control port.
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_CONFIRM       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_SMOKE_CONFIRM = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANOMALY_CONFIRM    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_HOLDOFF       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_HOLDOFF       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOKE_HOLDOFF      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANOMALY_HOLDOFF    = 3'd6;

   typedef enum logic [1:0] {
      KIND_FRAME,
      KIND_CLEAR,
      KIND_QUERY
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE,
      ST_DIVIDE
   } back_state_type;

   typedef struct packed {
      kind_type               kind;
      logic [CLASS_W-1:0]     alert_type;
      logic                   positive;
      logic [CONF_W-1:0]      confidence;
      logic [SRC_W-1:0]       source_id;
      logic [TIME_IN_W-1:0]   now_ms;
   } acq_item_type;

   typedef struct packed {
      logic [NUM_CONFIRM-1:0][CONFIRM_W-1:0] confirm;
      logic [NUM_CLASSES-1:0][HOLDOFF_W-1:0] holdoff;
   } acq_cfg_type;

endpackage
`default_nettype wire

// ===== hdl/acq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alert qualifier front end
// Accepts request transactions, decodes the opcode into an item kind and
// holds the items in a short queue for the back end.
// ----------------------------------------------------------------------------
module acq_front import acq_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [OPCODE_W-1:0]  req_opcode,
   input  wire logic [CLASS_W-1:0]   req_alert_type,
   input  wire logic                 req_positive,
   input  wire logic [CONF_W-1:0]    req_confidence,
   input  wire logic [SRC_W-1:0]     req_source_id,
   input  wire logic [TIME_IN_W-1:0] req_now_ms,
   output logic                      q_valid,
   output acq_item_type              q_item,
   input  wire logic                 q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   acq_item_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   acq_item_type     item_in;
   logic             push;
   logic             pop;

   always_comb begin
      item_in.alert_type = req_alert_type;
      item_in.positive   = req_positive;
      item_in.confidence = req_confidence;
      item_in.source_id  = req_source_id;
      item_in.now_ms     = req_now_ms;
      case (req_opcode)
         OP_FRAME: item_in.kind = KIND_FRAME;
         OP_CLEAR: item_in.kind = KIND_CLEAR;
         OP_QUERY: item_in.kind = KIND_QUERY;
         // The unused opcode behaves as a query.
         default:  item_in.kind = KIND_QUERY;
      endcase
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/acq_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alert qualifier divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acq_div #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic      [DIVIDEND_W-1:0] quotient,
   output logic                       done
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    diff;

   // The partial remainder stays below the divisor, so the top bit of the
   // difference is a clean borrow flag.
   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff      = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// ===== hdl/acq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Alert qualifier back end
// Holds the per-class qualifier state, executes one queued transaction at a
// time and drives the response register.
// ----------------------------------------------------------------------------
module acq_back import acq_pkg::*; #(
   parameter int RUN_MAX   = 255,
   parameter int TIME_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire acq_item_type          q_item,
   output logic                       q_pop,
   input  wire acq_cfg_type           cfg,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_fired,
   output logic [CLASS_W-1:0]         rsp_result_type,
   output logic [COUNT_W-1:0]         rsp_alert_number,
   output logic [FRAMES_W-1:0]        rsp_confirmed_frames,
   output logic [CONF_W-1:0]          rsp_mean_confidence,
   output logic [TIME_IN_W-1:0]       rsp_first_seen_ms,
   output logic [TIME_IN_W-1:0]       rsp_last_seen_ms,
   output logic [SRC_W-1:0]           rsp_result_source,
   output logic                       rsp_cooldown_active
);

   localparam int RUN_W  = $clog2(RUN_MAX + 1);
   localparam int HCMP_W = (TIME_BITS > HOLDOFF_W) ? TIME_BITS : HOLDOFF_W;
   localparam int CMP_W  = (RUN_W > CONFIRM_W) ? RUN_W : CONFIRM_W;

   // Per-class qualifier state.
   logic                 cooling_ff      [NUM_CLASSES];
   logic [TIME_BITS-1:0] fire_time_ff    [NUM_CLASSES];
   logic                 window_open_ff  [NUM_CLASSES];
   logic [TIME_BITS-1:0] window_start_ff [NUM_CLASSES];
   logic [RUN_W-1:0]     pos_run_ff      [NUM_CLASSES];
   logic [NEG_W-1:0]     neg_run_ff      [NUM_CLASSES];
   logic [TOTAL_W-1:0]   total_ff        [NUM_CLASSES];
   logic [TIME_BITS-1:0] last_pos_ff     [NUM_CLASSES];
   logic [COUNT_W-1:0]   fired_count_ff  [NUM_CLASSES];

   logic                 cooling_in;
   logic [TIME_BITS-1:0] fire_time_in;
   logic                 window_open_in;
   logic [TIME_BITS-1:0] window_start_in;
   logic [RUN_W-1:0]     pos_run_in;
   logic [NEG_W-1:0]     neg_run_in;
   logic [TOTAL_W-1:0]   total_in;
   logic [TIME_BITS-1:0] last_pos_in;
   logic [COUNT_W-1:0]   fired_count_in;

   back_state_type state_ff, state_in;
   acq_item_type   item_ff;
   logic           hold_ff, hold_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fired_ff, rsp_fired_in;
   logic [CLASS_W-1:0]   rsp_type_ff;
   logic [COUNT_W-1:0]   rsp_number_ff, rsp_number_in;
   logic [FRAMES_W-1:0]  rsp_frames_ff, rsp_frames_in;
   logic [CONF_W-1:0]    rsp_mean_ff;
   logic [TIME_IN_W-1:0] rsp_first_ff, rsp_first_in;
   logic [TIME_IN_W-1:0] rsp_last_ff, rsp_last_in;
   logic [SRC_W-1:0]     rsp_source_ff;
   logic                 rsp_cool_ff, rsp_cool_in;

   logic [CLASS_W-1:0]   cls;
   logic [HCMP_W-1:0]    now_wide;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic [CONFIRM_W-1:0] confirm_raw;
   logic [CONFIRM_W-1:0] confirm_eff;
   logic [TOTAL_W:0]     total_sum;
   logic                 fire;
   logic [TOTAL_W-1:0]   div_dividend;
   logic [RUN_W-1:0]     div_divisor;
   logic [TOTAL_W-1:0]   div_quotient;
   logic                 div_done;

   logic out_free;
   logic update_en;
   logic div_start;
   logic load_result;
   logic load_mean;

   assign cls      = item_ff.alert_type;
   assign now_wide = HCMP_W'(item_ff.now_ms);
   assign now_t    = now_wide[TIME_BITS-1:0];

   // Holdoff check, registered ahead of the state update.
   assign elapsed = now_t - fire_time_ff[cls];
   assign hold_in = cooling_ff[cls] &&
                    (HCMP_W'(elapsed) < HCMP_W'(cfg.holdoff[cls]));

   always_comb begin
      case (cls)
         CLASS_FALL:    confirm_raw = cfg.confirm[CONFIRM_FALL];
         CLASS_ANOMALY: confirm_raw = cfg.confirm[CONFIRM_ANOMALY];
         default:       confirm_raw = cfg.confirm[CONFIRM_FIRE_SMOKE];
      endcase
      confirm_eff = (confirm_raw == '0) ? CONFIRM_W'(1) : confirm_raw;
   end

   // New state of the addressed class and the response fields.
   always_comb begin
      cooling_in      = cooling_ff[cls];
      fire_time_in    = fire_time_ff[cls];
      window_open_in  = window_open_ff[cls];
      window_start_in = window_start_ff[cls];
      pos_run_in      = pos_run_ff[cls];
      neg_run_in      = neg_run_ff[cls];
      total_in        = total_ff[cls];
      last_pos_in     = last_pos_ff[cls];
      fired_count_in  = fired_count_ff[cls];
      total_sum       = '0;
      fire            = 1'b0;
      div_dividend    = '0;
      div_divisor     = '0;
      rsp_fired_in    = 1'b0;
      rsp_number_in   = '0;
      rsp_frames_in   = '0;
      rsp_first_in    = '0;
      rsp_last_in     = '0;
      rsp_cool_in     = 1'b0;
      case (item_ff.kind)
         KIND_FRAME: begin
            if (hold_ff) begin
               rsp_cool_in = 1'b1;
            end else begin
               cooling_in = 1'b0;
               if (!window_open_ff[cls]) begin
                  window_open_in  = 1'b1;
                  window_start_in = now_t;
               end
               if (item_ff.positive) begin
                  if (pos_run_ff[cls] < RUN_W'(RUN_MAX)) begin
                     pos_run_in = pos_run_ff[cls] + RUN_W'(1);
                  end
                  neg_run_in  = '0;
                  total_sum   = {1'b0, total_ff[cls]} + (TOTAL_W + 1)'(item_ff.confidence);
                  total_in    = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                  last_pos_in = now_t;
               end else begin
                  if (neg_run_ff[cls] < NEG_CLEAR) begin
                     neg_run_in = neg_run_ff[cls] + NEG_W'(1);
                  end
                  if (neg_run_in == NEG_CLEAR) begin
                     pos_run_in     = '0;
                     total_in       = '0;
                     window_open_in = 1'b0;
                  end
               end
               fire = (CMP_W'(pos_run_in) >= CMP_W'(confirm_eff));
               if (fire) begin
                  fired_count_in = fired_count_ff[cls] + COUNT_W'(1);
                  rsp_fired_in   = 1'b1;
                  rsp_number_in  = fired_count_in;
                  rsp_frames_in  = FRAMES_W'(pos_run_in);
                  rsp_first_in   = TIME_IN_W'(window_start_in);
                  rsp_last_in    = TIME_IN_W'(last_pos_in);
                  div_dividend   = total_in;
                  div_divisor    = pos_run_in;
                  // The holdoff starts now, so elapsed time is zero.
                  rsp_cool_in    = (cfg.holdoff[cls] != '0);
                  cooling_in     = 1'b1;
                  fire_time_in   = now_t;
                  pos_run_in     = '0;
                  total_in       = '0;
                  window_open_in = 1'b0;
               end
            end
         end
         KIND_CLEAR: begin
            cooling_in      = 1'b0;
            fire_time_in    = '0;
            window_open_in  = 1'b0;
            window_start_in = '0;
            pos_run_in      = '0;
            neg_run_in      = '0;
            total_in        = '0;
            last_pos_in     = '0;
            fired_count_in  = '0;
         end
         default: begin
            rsp_cool_in = hold_ff;
         end
      endcase
   end

   acq_div #(
      .DIVIDEND_W (TOTAL_W),
      .DIVISOR_W  (RUN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // The response register is empty, or empties in this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = fire ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop       = 1'b0;
      update_en   = 1'b0;
      div_start   = 1'b0;
      load_result = 1'b0;
      load_mean   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid && out_free;
         end
         ST_UPDATE: begin
            update_en   = 1'b1;
            div_start   = fire;
            load_result = 1'b1;
         end
         ST_DIVIDE: begin
            load_mean = div_done;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((load_result && !fire) || load_mean) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            cooling_ff[i]      <= 1'b0;
            fire_time_ff[i]    <= '0;
            window_open_ff[i]  <= 1'b0;
            window_start_ff[i] <= '0;
            pos_run_ff[i]      <= '0;
            neg_run_ff[i]      <= '0;
            total_ff[i]        <= '0;
            last_pos_ff[i]     <= '0;
            fired_count_ff[i]  <= '0;
         end
      end else if (update_en) begin
         cooling_ff[cls]      <= cooling_in;
         fire_time_ff[cls]    <= fire_time_in;
         window_open_ff[cls]  <= window_open_in;
         window_start_ff[cls] <= window_start_in;
         pos_run_ff[cls]      <= pos_run_in;
         neg_run_ff[cls]      <= neg_run_in;
         total_ff[cls]        <= total_in;
         last_pos_ff[cls]     <= last_pos_in;
         fired_count_ff[cls]  <= fired_count_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (load_result) begin
         rsp_fired_ff  <= rsp_fired_in;
         rsp_type_ff   <= item_ff.alert_type;
         rsp_number_ff <= rsp_number_in;
         rsp_frames_ff <= rsp_frames_in;
         rsp_mean_ff   <= '0;
         rsp_first_ff  <= rsp_first_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_source_ff <= item_ff.source_id;
         rsp_cool_ff   <= rsp_cool_in;
      end else if (load_mean) begin
         rsp_mean_ff <= div_quotient[CONF_W-1:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fired            = rsp_fired_ff;
   assign rsp_result_type      = rsp_type_ff;
   assign rsp_alert_number     = rsp_number_ff;
   assign rsp_confirmed_frames = rsp_frames_ff;
   assign rsp_mean_confidence  = rsp_mean_ff;
   assign rsp_first_seen_ms    = rsp_first_ff;
   assign rsp_last_seen_ms     = rsp_last_ff;
   assign rsp_result_source    = rsp_source_ff;
   assign rsp_cooldown_active  = rsp_cool_ff;

endmodule
`default_nettype wire

// ===== hdl/alert_confirm_cooldown_qualifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: the back end pops a queued request, checks the holdoff, updates the class
// state and loads the response; a frame that fires also waits for the 24-step
// mean-confidence divider. The back end works on one transaction at a time; a
// two-entry queue takes requests while the back end works.
// Reset: synchronous; clears all class state and loads confirm 3, holdoff 30000.
// ----------------------------------------------------------------------------
// Alert confirmation qualifier
// Per-class consecutive-confirmation debounce with holdoff for four alert
// classes, with the control registers and the front and back ends.
// ----------------------------------------------------------------------------
module alert_confirm_cooldown_qualifier import acq_pkg::*; #(
   parameter int RUN_MAX   = 255,
   parameter int TIME_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [OPCODE_W-1:0]    req_opcode,
   input  wire logic [CLASS_W-1:0]     req_alert_type,
   input  wire logic                   req_positive,
   input  wire logic [CONF_W-1:0]      req_confidence,
   input  wire logic [SRC_W-1:0]       req_source_id,
   input  wire logic [TIME_IN_W-1:0]   req_now_ms,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_fired,
   output logic [CLASS_W-1:0]          rsp_result_type,
   output logic [COUNT_W-1:0]          rsp_alert_number,
   output logic [FRAMES_W-1:0]         rsp_confirmed_frames,
   output logic [CONF_W-1:0]           rsp_mean_confidence,
   output logic [TIME_IN_W-1:0]        rsp_first_seen_ms,
   output logic [TIME_IN_W-1:0]        rsp_last_seen_ms,
   output logic [SRC_W-1:0]            rsp_result_source,
   output logic                        rsp_cooldown_active,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   acq_cfg_type  cfg_ff, cfg_in;
   logic         q_valid;
   acq_item_type q_item;
   logic         q_pop;

   assign csr_ready = 1'b1;

   // Writes to indexes beyond the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FALL_CONFIRM:       cfg_in.confirm[CONFIRM_FALL]       = csr_wdata[CONFIRM_W-1:0];
            CSR_FIRE_SMOKE_CONFIRM: cfg_in.confirm[CONFIRM_FIRE_SMOKE] = csr_wdata[CONFIRM_W-1:0];
            CSR_ANOMALY_CONFIRM:    cfg_in.confirm[CONFIRM_ANOMALY]    = csr_wdata[CONFIRM_W-1:0];
            CSR_FALL_HOLDOFF:       cfg_in.holdoff[CLASS_FALL]    = csr_wdata[HOLDOFF_W-1:0];
            CSR_FIRE_HOLDOFF:       cfg_in.holdoff[CLASS_FIRE]    = csr_wdata[HOLDOFF_W-1:0];
            CSR_SMOKE_HOLDOFF:      cfg_in.holdoff[CLASS_SMOKE]   = csr_wdata[HOLDOFF_W-1:0];
            CSR_ANOMALY_HOLDOFF:    cfg_in.holdoff[CLASS_ANOMALY] = csr_wdata[HOLDOFF_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CONFIRM; i++) begin
            cfg_ff.confirm[i] <= CONFIRM_RESET;
         end
         for (int i = 0; i < NUM_CLASSES; i++) begin
            cfg_ff.holdoff[i] <= HOLDOFF_RESET;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_alert_type (req_alert_type),
      .req_positive   (req_positive),
      .req_confidence (req_confidence),
      .req_source_id  (req_source_id),
      .req_now_ms     (req_now_ms),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   acq_back #(
      .RUN_MAX   (RUN_MAX),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop),
      .cfg                  (cfg_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_fired            (rsp_fired),
      .rsp_result_type      (rsp_result_type),
      .rsp_alert_number     (rsp_alert_number),
      .rsp_confirmed_frames (rsp_confirmed_frames),
      .rsp_mean_confidence  (rsp_mean_confidence),
      .rsp_first_seen_ms    (rsp_first_seen_ms),
      .rsp_last_seen_ms     (rsp_last_seen_ms),
      .rsp_result_source    (rsp_result_source),
      .rsp_cooldown_active  (rsp_cooldown_active)
   );

endmodule
`default_nettype wire

// ===== bench/alert_confirm_cooldown_qualifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alert confirmation qualifier testbench
// Drives request transactions with random gaps and response stalls, predicts
// each result from a behavioral copy of the per-class qualifier, and compares
// every response field in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module alert_confirm_cooldown_qualifier_tb;
   import acq_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RUN_LIMIT   = 255;

   localparam logic [OPCODE_W-1:0]    OP_SPARE    = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 3'd7;

   typedef struct packed {
      logic                 fired;
      logic [CLASS_W-1:0]   kind;
      logic [COUNT_W-1:0]   number;
      logic [FRAMES_W-1:0]  frames;
      logic [CONF_W-1:0]    mean;
      logic [TIME_IN_W-1:0] first_ms;
      logic [TIME_IN_W-1:0] last_ms;
      logic [SRC_W-1:0]     source;
      logic                 cooldown;
   } alert_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [CLASS_W-1:0]     req_alert_type;
   logic                   req_positive;
   logic [CONF_W-1:0]      req_confidence;
   logic [SRC_W-1:0]       req_source_id;
   logic [TIME_IN_W-1:0]   req_now_ms;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_fired;
   logic [CLASS_W-1:0]     rsp_result_type;
   logic [COUNT_W-1:0]     rsp_alert_number;
   logic [FRAMES_W-1:0]    rsp_confirmed_frames;
   logic [CONF_W-1:0]      rsp_mean_confidence;
   logic [TIME_IN_W-1:0]   rsp_first_seen_ms;
   logic [TIME_IN_W-1:0]   rsp_last_seen_ms;
   logic [SRC_W-1:0]       rsp_result_source;
   logic                   rsp_cooldown_active;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Behavioral copy of the qualifier state and its registers.
   logic                 cls_cooling     [NUM_CLASSES];
   logic [TIME_IN_W-1:0] cls_fire_ms     [NUM_CLASSES];
   logic                 cls_window_open [NUM_CLASSES];
   logic [TIME_IN_W-1:0] cls_window_ms   [NUM_CLASSES];
   logic [FRAMES_W-1:0]  cls_pos_run     [NUM_CLASSES];
   logic [NEG_W-1:0]     cls_neg_run     [NUM_CLASSES];
   logic [TOTAL_W-1:0]   cls_conf_total  [NUM_CLASSES];
   logic [TIME_IN_W-1:0] cls_last_pos_ms [NUM_CLASSES];
   logic [COUNT_W-1:0]   cls_alert_count [NUM_CLASSES];
   logic [CONFIRM_W-1:0] cfg_confirm     [NUM_CONFIRM];
   logic [HOLDOFF_W-1:0] cfg_holdoff     [NUM_CLASSES];

   alert_result_type     awaited_alerts[$];
   logic [TIME_IN_W-1:0] stamp;
   logic                 gaps_on;
   int                   cycles;
   int                   requests_sent;
   int                   results_seen;
   int                   alerts_fired;
   int                   csr_writes;
   int                   mismatch_count;

   alert_confirm_cooldown_qualifier DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_alert_type       (req_alert_type),
      .req_positive         (req_positive),
      .req_confidence       (req_confidence),
      .req_source_id        (req_source_id),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_fired            (rsp_fired),
      .rsp_result_type      (rsp_result_type),
      .rsp_alert_number     (rsp_alert_number),
      .rsp_confirmed_frames (rsp_confirmed_frames),
      .rsp_mean_confidence  (rsp_mean_confidence),
      .rsp_first_seen_ms    (rsp_first_seen_ms),
      .rsp_last_seen_ms     (rsp_last_seen_ms),
      .rsp_result_source    (rsp_result_source),
      .rsp_cooldown_active  (rsp_cooldown_active),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int confirm_needed(input logic [CLASS_W-1:0] c);
      logic [CONFIRM_W-1:0] v;
      if (c == CLASS_FALL) v = cfg_confirm[CONFIRM_FALL];
      else if (c == CLASS_ANOMALY) v = cfg_confirm[CONFIRM_ANOMALY];
      else v = cfg_confirm[CONFIRM_FIRE_SMOKE];
      return (v == 0) ? 1 : int'(v);
   endfunction

   function automatic logic holding(input logic [CLASS_W-1:0] c,
                                    input logic [TIME_IN_W-1:0] now);
      logic [TIME_IN_W-1:0] elapsed;
      elapsed = now - cls_fire_ms[c];
      return cls_cooling[c] && (elapsed < cfg_holdoff[c]);
   endfunction

   function automatic alert_result_type qualify_request(
      input logic [OPCODE_W-1:0] op,
      input logic [CLASS_W-1:0] c,
      input logic pos,
      input logic [CONF_W-1:0] conf,
      input logic [SRC_W-1:0] src,
      input logic [TIME_IN_W-1:0] now);
      alert_result_type res;
      logic [TOTAL_W:0] total;
      logic [TOTAL_W-1:0] quotient;
      res = '0;
      res.kind = c;
      res.source = src;
      if (op == OP_CLEAR) begin
         cls_cooling[c] = 1'b0;
         cls_fire_ms[c] = '0;
         cls_window_open[c] = 1'b0;
         cls_window_ms[c] = '0;
         cls_pos_run[c] = '0;
         cls_neg_run[c] = '0;
         cls_conf_total[c] = '0;
         cls_last_pos_ms[c] = '0;
         cls_alert_count[c] = '0;
      end else if (op != OP_FRAME) begin
         res.cooldown = holding(c, now);
      end else if (holding(c, now)) begin
         res.cooldown = 1'b1;
      end else begin
         cls_cooling[c] = 1'b0;
         // Any processed frame opens a closed window, negative ones too.
         if (!cls_window_open[c]) begin
            cls_window_open[c] = 1'b1;
            cls_window_ms[c] = now;
         end
         if (pos) begin
            if (cls_pos_run[c] != RUN_LIMIT) cls_pos_run[c] = cls_pos_run[c] + 1'b1;
            cls_neg_run[c] = '0;
            total = cls_conf_total[c] + conf;
            cls_conf_total[c] = total[TOTAL_W] ? {TOTAL_W{1'b1}} : total[TOTAL_W-1:0];
            cls_last_pos_ms[c] = now;
         end else begin
            if (cls_neg_run[c] != NEG_CLEAR) cls_neg_run[c] = cls_neg_run[c] + 1'b1;
            if (cls_neg_run[c] == NEG_CLEAR) begin
               cls_pos_run[c] = '0;
               cls_conf_total[c] = '0;
               cls_window_open[c] = 1'b0;
            end
         end
         // The negative run is left alone when the class fires.
         if (int'(cls_pos_run[c]) >= confirm_needed(c)) begin
            cls_alert_count[c] = cls_alert_count[c] + 1'b1;
            quotient = cls_conf_total[c] / {{(TOTAL_W-FRAMES_W){1'b0}}, cls_pos_run[c]};
            res.fired = 1'b1;
            res.number = cls_alert_count[c];
            res.frames = cls_pos_run[c];
            res.mean = quotient[CONF_W-1:0];
            res.first_ms = cls_window_ms[c];
            res.last_ms = cls_last_pos_ms[c];
            cls_cooling[c] = 1'b1;
            cls_fire_ms[c] = now;
            cls_pos_run[c] = '0;
            cls_conf_total[c] = '0;
            cls_window_open[c] = 1'b0;
         end
         res.cooldown = holding(c, now);
      end
      return res;
   endfunction

   // Called right after a rising edge; leaves req_valid high after acceptance.
   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic [CLASS_W-1:0] c,
                               input logic pos,
                               input logic [CONF_W-1:0] conf,
                               input logic [SRC_W-1:0] src,
                               input logic [TIME_IN_W-1:0] now);
      int gap;
      gap = 0;
      while (gaps_on && $urandom_range(99) < 26) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_alert_type <= c;
      req_positive <= pos;
      req_confidence <= conf;
      req_source_id <= src;
      req_now_ms <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_alerts.push_back(qualify_request(op, c, pos, conf, src, now));
      requests_sent++;
   endtask

   task automatic settle(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_alerts.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FALL_CONFIRM:       cfg_confirm[CONFIRM_FALL] = data[CONFIRM_W-1:0];
         CSR_FIRE_SMOKE_CONFIRM: cfg_confirm[CONFIRM_FIRE_SMOKE] = data[CONFIRM_W-1:0];
         CSR_ANOMALY_CONFIRM:    cfg_confirm[CONFIRM_ANOMALY] = data[CONFIRM_W-1:0];
         CSR_FALL_HOLDOFF:       cfg_holdoff[CLASS_FALL] = data;
         CSR_FIRE_HOLDOFF:       cfg_holdoff[CLASS_FIRE] = data;
         CSR_SMOKE_HOLDOFF:      cfg_holdoff[CLASS_SMOKE] = data;
         CSR_ANOMALY_HOLDOFF:    cfg_holdoff[CLASS_ANOMALY] = data;
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Confirm counts carry random upper bits to check the width masking.
   task automatic apply_settings(input logic [CONFIRM_W-1:0] fall_need,
                                 input logic [CONFIRM_W-1:0] fire_smoke_need,
                                 input logic [CONFIRM_W-1:0] anomaly_need,
                                 input logic [HOLDOFF_W-1:0] fall_hold,
                                 input logic [HOLDOFF_W-1:0] fire_hold,
                                 input logic [HOLDOFF_W-1:0] smoke_hold,
                                 input logic [HOLDOFF_W-1:0] anomaly_hold);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom();
      write_csr(CSR_FALL_CONFIRM, {junk[31:8], fall_need});
      junk = $urandom();
      write_csr(CSR_FIRE_SMOKE_CONFIRM, {junk[31:8], fire_smoke_need});
      junk = $urandom();
      write_csr(CSR_ANOMALY_CONFIRM, {junk[31:8], anomaly_need});
      write_csr(CSR_FALL_HOLDOFF, fall_hold);
      write_csr(CSR_FIRE_HOLDOFF, fire_hold);
      write_csr(CSR_SMOKE_HOLDOFF, smoke_hold);
      write_csr(CSR_ANOMALY_HOLDOFF, anomaly_hold);
   endtask

   // Mostly positive runs on one class long enough to fire, with negatives and
   // stray transactions of every kind mixed in.
   task automatic random_traffic(input int quota);
      int target;
      int len;
      int i;
      int pick;
      logic [CLASS_W-1:0] c;
      target = requests_sent + quota;
      while (requests_sent < target) begin
         c = CLASS_W'($urandom_range(0, 3));
         len = confirm_needed(c) + $urandom_range(0, 2);
         if (len > 12) len = $urandom_range(1, 12);
         pick = $urandom_range(99);
         if (pick < 30) stamp = stamp + $urandom_range(0, 40000);
         else if (pick < 35) stamp = stamp + $urandom();
         if (pick >= 92)
            send_request(OP_CLEAR, c, 1'($urandom_range(0, 1)), CONF_W'($urandom()),
                         SRC_W'($urandom()), stamp);
         for (i = 0; i < len; i++) begin
            stamp = stamp + $urandom_range(0, 40);
            pick = $urandom_range(99);
            if (pick < 84)
               send_request(OP_FRAME, c, 1'b1, CONF_W'($urandom()), SRC_W'($urandom()),
                            stamp);
            else if (pick < 94)
               send_request(OP_FRAME, c, 1'b0, CONF_W'($urandom()), SRC_W'($urandom()),
                            stamp);
            else
               send_request(OPCODE_W'($urandom_range(0, 3)), CLASS_W'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), CONF_W'($urandom()),
                            SRC_W'($urandom()), stamp);
         end
         if ($urandom_range(99) < 4) settle(0);
      end
   endtask

   task automatic test_reset_values;
      send_request(OP_FRAME, CLASS_FALL, 1'b1, 16'hFFFF, 8'h00, 32'hFFFF_FFF0);
      send_request(OP_FRAME, CLASS_FALL, 1'b1, 16'h0000, 8'hFF, 32'hFFFF_FFF8);
      // Third positive fires across the time wrap.
      send_request(OP_FRAME, CLASS_FALL, 1'b1, 16'h8001, 8'h5A, 32'h0000_0004);
      send_request(OP_FRAME, CLASS_FALL, 1'b1, 16'h1234, 8'hA5, 32'h0000_0010);
      send_request(OP_QUERY, CLASS_FALL, 1'b0, 16'h0000, 8'h01, 32'd4 + 32'd29999);
      send_request(OP_QUERY, CLASS_FALL, 1'b0, 16'h0000, 8'h02, 32'd4 + HOLDOFF_RESET);
      // Holdoff has run out, so this negative frame opens the next window.
      send_request(OP_FRAME, CLASS_FALL, 1'b0, 16'hFFFF, 8'h03, 32'd4 + HOLDOFF_RESET);
      send_request(OP_FRAME, CLASS_FALL, 1'b1, 16'h00FF, 8'h04, 32'd30010);
      send_request(OP_FRAME, CLASS_FALL, 1'b1, 16'hFF00, 8'h05, 32'd30020);
      send_request(OP_FRAME, CLASS_FALL, 1'b1, 16'h0001, 8'h06, 32'd30030);
   endtask

   task automatic test_negative_runs;
      stamp = 32'h0001_0000;
      send_request(OP_FRAME, CLASS_FIRE, 1'b1, 16'h4000, 8'h10, stamp);
      send_request(OP_FRAME, CLASS_FIRE, 1'b0, 16'h4000, 8'h11, stamp + 10);
      send_request(OP_FRAME, CLASS_FIRE, 1'b0, 16'h4000, 8'h12, stamp + 20);
      send_request(OP_FRAME, CLASS_FIRE, 1'b1, 16'h2000, 8'h13, stamp + 30);
      send_request(OP_FRAME, CLASS_FIRE, 1'b1, 16'h1000, 8'h14, stamp + 40);
      send_request(OP_FRAME, CLASS_SMOKE, 1'b1, 16'h7777, 8'h20, stamp + 50);
      send_request(OP_FRAME, CLASS_SMOKE, 1'b1, 16'h7777, 8'h21, stamp + 60);
      send_request(OP_FRAME, CLASS_SMOKE, 1'b0, 16'h0000, 8'h22, stamp + 70);
      send_request(OP_FRAME, CLASS_SMOKE, 1'b0, 16'h0000, 8'h23, stamp + 80);
      send_request(OP_FRAME, CLASS_SMOKE, 1'b0, 16'h0000, 8'h24, stamp + 90);
      send_request(OP_FRAME, CLASS_SMOKE, 1'b1, 16'h7777, 8'h25, stamp + 100);
   endtask

   task automatic test_clear_and_query;
      send_request(OP_FRAME, CLASS_ANOMALY, 1'b1, 16'hABCD, 8'h30, 32'h0002_0000);
      send_request(OP_FRAME, CLASS_ANOMALY, 1'b1, 16'hABCD, 8'h31, 32'h0002_0010);
      send_request(OP_CLEAR, CLASS_ANOMALY, 1'b1, 16'hFFFF, 8'h32, 32'h0002_0020);
      send_request(OP_SPARE, CLASS_ANOMALY, 1'b0, 16'h0000, 8'h33, 32'hFFFF_FFFF);
      send_request(OP_QUERY, CLASS_FIRE, 1'b0, 16'h0000, 8'h34, 32'h0000_0000);
      // After the clear this positive starts a fresh run and cannot fire.
      send_request(OP_FRAME, CLASS_ANOMALY, 1'b1, 16'h1111, 8'h35, 32'h0002_0030);
   endtask

   task automatic test_default_traffic;
      stamp = 32'h0010_0000;
      random_traffic(150);
   endtask

   task automatic test_config_extremes;
      settle(40);
      apply_settings(8'd0, 8'd1, 8'd2, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd250);
      write_csr(CSR_UNUSED, $urandom());
      random_traffic(150);
   endtask

   task automatic test_no_idle;
      settle(40);
      apply_settings(8'd5, 8'd2, 8'd1, 32'd100, 32'd0, 32'd30000, 32'hFFFF_FFFF);
      gaps_on = 1'b0;
      stamp = 32'hFFFF_F000;
      random_traffic(150);
      gaps_on = 1'b1;
   endtask

   task automatic test_long_run;
      int run;
      settle(40);
      apply_settings(8'd255, 8'd255, 8'd255, 32'd20, 32'd20, 32'd20, 32'd20);
      run = 0;
      while (run < 255) begin
         stamp = stamp + $urandom_range(1, 30);
         // Pairs of negatives must not break the run.
         if (run % 80 == 40) begin
            send_request(OP_FRAME, CLASS_FIRE, 1'b0, CONF_W'($urandom()), SRC_W'($urandom()),
                         stamp);
            send_request(OP_FRAME, CLASS_FIRE, 1'b0, CONF_W'($urandom()), SRC_W'($urandom()),
                         stamp);
         end
         send_request(OP_FRAME, CLASS_FIRE, 1'b1, 16'hFFFF, SRC_W'($urandom()), stamp);
         run++;
      end
      random_traffic(40);
   endtask

   always @(posedge clock) begin : check_results
      alert_result_type seen;
      alert_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.fired = rsp_fired;
            seen.kind = rsp_result_type;
            seen.number = rsp_alert_number;
            seen.frames = rsp_confirmed_frames;
            seen.mean = rsp_mean_confidence;
            seen.first_ms = rsp_first_seen_ms;
            seen.last_ms = rsp_last_seen_ms;
            seen.source = rsp_result_source;
            seen.cooldown = rsp_cooldown_active;
            results_seen++;
            if (rsp_fired === 1'b1) alerts_fired++;
            if (awaited_alerts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected response at cycle %0d", cycles);
            end else begin
               want = awaited_alerts.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch at cycle %0d, response %0d", cycles, results_seen);
                     $display("  expected fired=%0d type=%0d num=%0d frames=%0d mean=%h",
                              want.fired, want.kind, want.number, want.frames, want.mean);
                     $display("           first=%h last=%h src=%h cool=%0d",
                              want.first_ms, want.last_ms, want.source, want.cooldown);
                     $display("  actual   fired=%0d type=%0d num=%0d frames=%0d mean=%h",
                              seen.fired, seen.kind, seen.number, seen.frames, seen.mean);
                     $display("           first=%h last=%h src=%h cool=%0d",
                              seen.first_ms, seen.last_ms, seen.source, seen.cooldown);
                  end
               end
            end
         end
         rsp_stall <= gaps_on && ($urandom_range(99) < 26);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int i;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_FRAME;
      req_alert_type = CLASS_FALL;
      req_positive = 1'b0;
      req_confidence = '0;
      req_source_id = '0;
      req_now_ms = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_FALL_CONFIRM;
      csr_wdata = '0;
      gaps_on = 1'b1;
      cycles = 0;
      requests_sent = 0;
      results_seen = 0;
      alerts_fired = 0;
      csr_writes = 0;
      mismatch_count = 0;
      for (i = 0; i < NUM_CLASSES; i++) begin
         cls_cooling[i] = 1'b0;
         cls_fire_ms[i] = '0;
         cls_window_open[i] = 1'b0;
         cls_window_ms[i] = '0;
         cls_pos_run[i] = '0;
         cls_neg_run[i] = '0;
         cls_conf_total[i] = '0;
         cls_last_pos_ms[i] = '0;
         cls_alert_count[i] = '0;
         cfg_holdoff[i] = HOLDOFF_RESET;
      end
      for (i = 0; i < NUM_CONFIRM; i++) cfg_confirm[i] = CONFIRM_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_negative_runs();
      test_clear_and_query();
      test_default_traffic();
      test_config_extremes();
      test_no_idle();
      test_long_run();

      settle(40);
      $display("Sent %0d requests over four register settings; %0d responses, %0d alerts fired",
               requests_sent, results_seen, alerts_fired);
      $display("Register writes: %0d, mismatches: %0d", csr_writes, mismatch_count);
      if (mismatch_count == 0 && awaited_alerts.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
